// File: rtl/srce_pkg.sv
// Shared types and constants for the state relation closure engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package srce_pkg;

  // Relation geometry
  localparam int unsigned MAX_STATES = 32;
  localparam int unsigned ROW_W      = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_STATES);
  localparam int unsigned CNT_W      = 6;

  // Input field widths
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned TARGET_W = 5;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_STATES_IN_USE = 1'b0;
  localparam logic [CNT_W-1:0] STATES_RESET = CNT_W'(32);

  // Item modes
  localparam logic [MODE_W-1:0] MODE_IMAGE           = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CLOSURE         = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_CROSS_SET   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADD_CROSS_STATE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE          = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR           = 3'd5;

  // Request from the sequencer to the row memory
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] raddr;
    logic             wr_en;
    logic [IDX_W-1:0] waddr;
    logic [ROW_W-1:0] wdata;
    logic             clr;
  } mem_req_t;

endpackage
`default_nettype wire

// File: rtl/srce_if.sv
// Valid/ready channel interfaces for item input and result output.
// Depends on srce_pkg for field widths.
`default_nettype none
interface srce_in_if;
  import srce_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ROW_W-1:0]    set_a;
  logic [ROW_W-1:0]    set_b;
  logic [TARGET_W-1:0] target_state;

  modport source (output valid, mode, set_a, set_b, target_state, input ready);
  modport sink   (input valid, mode, set_a, set_b, target_state, output ready);
endinterface

interface srce_out_if;
  import srce_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] result_set;

  modport source (output valid, result_set, input ready);
  modport sink   (input valid, result_set, output ready);
endinterface
`default_nettype wire

// File: rtl/state_relation_closure_engine_core.sv
// Usage
//   Items arrive on in_ch (mode, set_a, set_b, target_state) and each one
//   yields exactly one result_set on out_ch; a transfer happens on a rising
//   edge with valid and ready high. states_in_use is written over the APB
//   port at byte address 0; it reads back there too. The user must write it
//   only while the block is idle; the block itself does not enforce this.
//   The relation lives in a 32-row memory swept one row per cycle with
//   registered read data. Image and the update modes take one pass over
//   the rows. Closure takes one pass per growth step plus a final pass,
//   from 1 up to 32 passes. Clear and undefined modes skip the pass and
//   go straight to the result. One item is in work at a time; in_ch.ready
//   is high only while the sequencer is idle.
//   A finished result sits in an output register; the sequencer may close
//   its next item behind it, and holds that one while the receiver stalls.
//   Reset empties the relation at once (per-row valid bits) and sets
//   states_in_use to 32.
// Depends on srce_pkg, srce_if, srce_row_mem and srce_engine.
`default_nettype none
module state_relation_closure_engine_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  srce_in_if.sink                           in_ch,
  srce_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [srce_pkg::APB_AW-1:0]  paddr,
  input  wire logic [srce_pkg::APB_DW-1:0]  pwdata,
  output logic [srce_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);
  import srce_pkg::*;

  logic [CNT_W-1:0] states_q;
  logic             cfg_wr;
  logic             reg_idx;

  mem_req_t         mem_req;
  logic [ROW_W-1:0] mem_rdata;

  logic             res_valid;
  logic             res_ready;
  logic [ROW_W-1:0] res_set;

  logic             out_vld_q, out_vld_d;
  logic [ROW_W-1:0] out_set_q, out_set_d;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_STATES_IN_USE);
  assign prdata  = (reg_idx == REG_STATES_IN_USE) ? APB_DW'(states_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      states_q <= STATES_RESET;
    end else if (cfg_wr) begin
      states_q <= pwdata[CNT_W-1:0];
    end
  end

  srce_row_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  srce_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .states_in_use_i (states_q),
    .in_valid_i      (in_ch.valid),
    .in_ready_o      (in_ch.ready),
    .mode_i          (in_ch.mode),
    .set_a_i         (in_ch.set_a),
    .set_b_i         (in_ch.set_b),
    .target_state_i  (in_ch.target_state),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_set_o       (res_set),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata)
  );

  // Output register: load when empty or when the held result transfers
  assign res_ready = !out_vld_q || out_ch.ready;

  always_comb begin
    out_vld_d = out_vld_q;
    out_set_d = out_set_q;
    if (res_valid && res_ready) begin
      out_vld_d = 1'b1;
      out_set_d = res_set;
    end else if (out_ch.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_set_q <= out_set_d;
  end

  assign out_ch.valid      = out_vld_q;
  assign out_ch.result_set = out_set_q;

`ifndef SYNTHESIS
  // The engine only hands over a result the register can take
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ch.ready |-> !(res_valid && res_ready))
    else $error("output register overwritten while stalled");

  // Domain size never changes while an item is in work
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |=> $stable(states_q))
    else $error("states_in_use changed during an item");

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ch.ready |=> out_vld_q && $stable(out_set_q))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// File: rtl/srce_row_mem.sv
// Relation row store: one synchronous memory with registered read data,
// plus per-row valid bits so reset and clear empty the relation at once.
// Depends on srce_pkg.
`default_nettype none
module srce_row_mem (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire srce_pkg::mem_req_t         req_i,
  output logic [srce_pkg::ROW_W-1:0]      rdata_o
);
  import srce_pkg::*;

  logic [ROW_W-1:0]      mem [MAX_STATES];
  logic [MAX_STATES-1:0] row_vld_q;
  logic [ROW_W-1:0]      rdata_q;
  logic                  rd_vld_q;

  // Write and read the row array
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // Track which rows hold data; clear drops them all
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.clr) begin
        row_vld_q <= '0;
      end else if (req_i.wr_en) begin
        row_vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.raddr];
      end
    end
  end

  // An empty row reads as zero
  assign rdata_o = rd_vld_q ? rdata_q : '0;

endmodule
`default_nettype wire

// File: rtl/srce_engine.sv
// Sequencer: sweeps the row memory once per pass, accumulating images or
// doing read-modify-write updates, and repeats passes for closure.
// Depends on srce_pkg; drives srce_row_mem through mem_req_t.
`default_nettype none
module srce_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [srce_pkg::CNT_W-1:0]    states_in_use_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [srce_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [srce_pkg::ROW_W-1:0]    set_a_i,
  input  wire logic [srce_pkg::ROW_W-1:0]    set_b_i,
  input  wire logic [srce_pkg::TARGET_W-1:0] target_state_i,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output logic [srce_pkg::ROW_W-1:0]         res_set_o,
  output srce_pkg::mem_req_t                 mem_req_o,
  input  wire logic [srce_pkg::ROW_W-1:0]    mem_rdata_i
);
  import srce_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  localparam logic [CNT_W-1:0] DOMAIN_MAX = CNT_W'(MAX_STATES);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(MAX_STATES - 1);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [ROW_W-1:0]  acc_q, acc_d;
  logic [ROW_W-1:0]  nxt_q, nxt_d;
  logic [ROW_W-1:0]  b_q, b_d;
  logic [ROW_W-1:0]  mask_q, mask_d;
  logic [ROW_W-1:0]  res_q, res_d;

  logic              accept;
  logic [CNT_W-1:0]  n_cap;
  logic [ROW_W-1:0]  in_mask;
  logic              tgt_hit;
  logic              is_query;
  logic              row_sel;
  logic [ROW_W-1:0]  row_img;
  logic [ROW_W-1:0]  nxt_full;
  logic [ROW_W-1:0]  nxt_masked;
  logic [ROW_W-1:0]  row_mod;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == ST_RESULT);
  assign res_set_o   = res_q;

  // Domain size and mask for the incoming item
  always_comb begin
    n_cap   = (states_in_use_i > DOMAIN_MAX) ? DOMAIN_MAX : states_in_use_i;
    in_mask = (n_cap >= CNT_W'(ROW_W)) ? '1 : ((ROW_W'(1) << n_cap) - ROW_W'(1));
    tgt_hit = ({1'b0, target_state_i} < n_cap);
  end

  // Combine the row returned by the memory
  always_comb begin
    is_query   = (mode_q == MODE_IMAGE) || (mode_q == MODE_CLOSURE);
    row_sel    = rd_vld_q && acc_q[rd_idx_q];
    row_img    = row_sel ? mem_rdata_i : '0;
    nxt_full   = nxt_q | row_img;
    nxt_masked = nxt_full & mask_q;
    row_mod    = (mode_q == MODE_REMOVE) ? (mem_rdata_i & ~b_q) : (mem_rdata_i | b_q);
  end

  // Memory requests: read ahead by one row, write back the row just read
  always_comb begin
    mem_req_o.rd_en = (state_q == ST_SCAN);
    mem_req_o.raddr = idx_q;
    mem_req_o.wr_en = row_sel && !is_query;
    mem_req_o.waddr = rd_idx_q;
    mem_req_o.wdata = row_mod;
    mem_req_o.clr   = accept && (mode_i == MODE_CLEAR);
  end

  // Sequence the passes
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    rd_vld_d = 1'b0;
    rd_idx_d = rd_idx_q;
    mode_d   = mode_q;
    acc_d    = acc_q;
    nxt_d    = nxt_q;
    b_d      = b_q;
    mask_d   = mask_q;
    res_d    = res_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d = mode_i;
          mask_d = in_mask;
          acc_d  = set_a_i & in_mask;
          nxt_d  = '0;
          idx_d  = '0;
          res_d  = '0;
          b_d    = set_b_i & in_mask;
          case (mode_i)
            MODE_IMAGE, MODE_CLOSURE, MODE_ADD_CROSS_SET, MODE_REMOVE: begin
              state_d = ST_SCAN;
            end
            MODE_ADD_CROSS_STATE: begin
              b_d     = tgt_hit ? (ROW_W'(1) << target_state_i) : '0;
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_RESULT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        nxt_d    = nxt_full;
        rd_vld_d = 1'b1;
        rd_idx_d = idx_q;
        idx_d    = idx_q + IDX_W'(1);
        if (idx_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Last row is in; close the pass
        nxt_d = '0;
        idx_d = '0;
        if (mode_q == MODE_IMAGE) begin
          res_d   = nxt_masked;
          state_d = ST_RESULT;
        end else if (mode_q == MODE_CLOSURE) begin
          if ((nxt_masked & ~acc_q) != '0) begin
            acc_d   = acc_q | nxt_masked;
            state_d = ST_SCAN;
          end else begin
            res_d   = acc_q;
            state_d = ST_RESULT;
          end
        end else begin
          res_d   = '0;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      idx_q    <= idx_d;
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    mode_q   <= mode_d;
    acc_q    <= acc_d;
    nxt_q    <= nxt_d;
    b_q      <= b_d;
    mask_q   <= mask_d;
    res_q    <= res_d;
  end

`ifndef SYNTHESIS
  // A write-back never lands on the row being fetched
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.rd_en && mem_req_o.wr_en |-> mem_req_o.raddr != mem_req_o.waddr)
    else $error("row read and write-back collide");

  // Queries never modify the relation
  a_query_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> !is_query && (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("row write outside an update pass");

  // Update modes report an empty set
  a_update_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !is_query |-> res_set_o == '0)
    else $error("update item returned a nonzero set");

  // A result stays put until it is taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_set_o))
    else $error("engine result dropped before transfer");
`endif

endmodule
`default_nettype wire

// File: bench/tb_state_relation_closure_engine_core.sv
`timescale 1ns / 1ps
// Self-checking bench for state_relation_closure_engine_core: directed table, then random phases.
// Depends on srce_pkg, srce_if and the core; a local relation predictor checks each result.
module tb_state_relation_closure_engine_core;
  import srce_pkg::*;

  // Modes the block does not define; they must leave the relation alone
  localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;
  localparam logic [APB_AW-1:0] ADDR_STATES  = APB_AW'(4 * REG_STATES_IN_USE);
  localparam int unsigned       STALL_LIMIT  = 8000;
  localparam int unsigned       LONG_HOLD    = 200;
  localparam int unsigned       NUM_PHASES   = 8;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ROW_W-1:0]    set_a;
    logic [ROW_W-1:0]    set_b;
    logic [TARGET_W-1:0] target;
  } rel_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] dom;
    rel_item_t        item;
    logic             fixed;
    logic [ROW_W-1:0] want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  srce_in_if  in_if ();
  srce_out_if out_if ();

  state_relation_closure_engine_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: relation rows and the active domain register
  logic [ROW_W-1:0] rel_rows [MAX_STATES];
  logic [CNT_W-1:0] states_cfg;

  logic [ROW_W-1:0] pending_sets [$];
  dir_row_t         dir_tab [$];
  int unsigned      mismatches;
  int unsigned      quiet_cycles;
  logic             idle_on;
  logic             hold_req;
  int unsigned      phase_dom [NUM_PHASES] = '{32, 1, 0, 63, 7, 33, 20, 32};
  int unsigned      phase_len [NUM_PHASES] = '{170, 40, 30, 150, 100, 60, 120, 100};

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned active_states();
    int unsigned n;
    n = states_cfg;
    if (n > ROW_W) n = ROW_W;
    if (n > MAX_STATES) n = MAX_STATES;
    return n;
  endfunction

  function automatic logic [ROW_W-1:0] image_of_set(input logic [ROW_W-1:0] s,
                                                    input int unsigned n,
                                                    input logic [ROW_W-1:0] m);
    logic [ROW_W-1:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (s[i]) acc |= rel_rows[i];
    end
    return acc & m;
  endfunction

  // Apply one item to the predicted relation and return its result set
  function automatic logic [ROW_W-1:0] relation_step(input rel_item_t it);
    int unsigned n;
    logic [ROW_W-1:0] m;
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] acc;
    logic [ROW_W-1:0] nxt;
    logic [ROW_W-1:0] res;
    n   = active_states();
    m   = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
    a   = it.set_a & m;
    b   = it.set_b & m;
    res = '0;
    case (it.mode)
      MODE_IMAGE: begin
        res = image_of_set(a, n, m);
      end
      MODE_CLOSURE: begin
        acc = a;
        nxt = image_of_set(acc, n, m);
        while ((nxt & ~acc) != '0) begin
          acc |= nxt;
          nxt = image_of_set(acc, n, m);
        end
        res = acc;
      end
      MODE_ADD_CROSS_SET: begin
        for (int unsigned i = 0; i < n; i++) if (a[i]) rel_rows[i] |= b;
      end
      MODE_ADD_CROSS_STATE: begin
        if (it.target < n) begin
          for (int unsigned i = 0; i < n; i++) if (a[i]) rel_rows[i][it.target] = 1'b1;
        end
      end
      MODE_REMOVE: begin
        for (int unsigned i = 0; i < n; i++) if (a[i]) rel_rows[i] &= ~b;
      end
      MODE_CLEAR: begin
        for (int unsigned i = 0; i < MAX_STATES; i++) rel_rows[i] = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic rel_item_t mk_item(input logic [MODE_W-1:0] mode,
                                        input logic [ROW_W-1:0] a,
                                        input logic [ROW_W-1:0] b,
                                        input logic [TARGET_W-1:0] t);
    rel_item_t it;
    it.mode   = mode;
    it.set_a  = a;
    it.set_b  = b;
    it.target = t;
    return it;
  endfunction

  function automatic dir_row_t drow(input logic [CNT_W-1:0] dom, input rel_item_t it,
                                    input logic fixed, input logic [ROW_W-1:0] want);
    dir_row_t r;
    r.dom   = dom;
    r.item  = it;
    r.fixed = fixed;
    r.want  = want;
    return r;
  endfunction

  // A handful of states inside the span, so the relation stays sparse
  function automatic logic [ROW_W-1:0] few_states(input int unsigned span,
                                                  input int unsigned cnt);
    logic [ROW_W-1:0] s;
    s = '0;
    for (int unsigned k = 0; k < cnt; k++) s[$urandom_range(0, span - 1)] = 1'b1;
    return s;
  endfunction

  function automatic rel_item_t rand_item();
    rel_item_t   it;
    int unsigned span;
    int unsigned r;
    span = active_states();
    if (span == 0) span = ROW_W;
    r = $urandom_range(0, 99);
    it.set_a  = ($urandom_range(0, 3) == 0) ? ROW_W'($urandom) :
                few_states(span, $urandom_range(1, 3));
    it.set_b  = ($urandom_range(0, 5) == 0) ? ROW_W'($urandom) :
                few_states(span, $urandom_range(1, 2));
    it.target = ($urandom_range(0, 7) == 0) ? TARGET_W'($urandom_range(0, 31)) :
                TARGET_W'($urandom_range(0, span - 1));
    if (r < 20) it.mode = MODE_IMAGE;
    else if (r < 45) it.mode = MODE_CLOSURE;
    else if (r < 63) it.mode = MODE_ADD_CROSS_SET;
    else if (r < 78) it.mode = MODE_ADD_CROSS_STATE;
    else if (r < 89) it.mode = MODE_REMOVE;
    else if (r < 92) it.mode = MODE_CLEAR;
    else if (r < 95) it.mode = ($urandom_range(0, 1) == 0) ? MODE_RSVD_LO : MODE_RSVD_HI;
    else begin
      // noise: any mode, dense random sets
      it.mode  = MODE_W'($urandom_range(0, 7));
      it.set_a = ROW_W'($urandom);
      it.set_b = ROW_W'($urandom);
    end
    return it;
  endfunction

  // Offer one item, after a random gap when idle_on is set; predict it once the transfer happens
  task automatic send_item(input rel_item_t it, input logic fixed,
                           input logic [ROW_W-1:0] want);
    int unsigned gap;
    logic [ROW_W-1:0] predicted;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid        <= 1'b1;
    in_if.mode         <= it.mode;
    in_if.set_a        <= it.set_a;
    in_if.set_b        <= it.set_b;
    in_if.target_state <= it.target;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = relation_step(it);
    pending_sets.push_back(fixed ? want : predicted);
  endtask

  // Drop valid and hold until every predicted result has been checked
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_sets.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the domain register, then read it back
  task automatic write_states(input logic [CNT_W-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_STATES;
    pwdata  <= APB_DW'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    states_cfg = v;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CNT_W-1:0] !== v)
      report_mismatch($sformatf("states_in_use read %0d, wrote %0d", prdata[CNT_W-1:0], v));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: random stall per result, plus one long hold-off on request
  initial begin
    int unsigned stall;
    logic        held;
    held = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        @(negedge clk_i);
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    logic [ROW_W-1:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_sets.size() == 0) begin
        report_mismatch($sformatf("result %08h with nothing pending", out_if.result_set));
      end else begin
        want = pending_sets.pop_front();
        if (out_if.result_set !== want)
          report_mismatch($sformatf("result_set %08h, want %08h", out_if.result_set, want));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_state_relation_closure_engine_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.mode         = MODE_IMAGE;
    in_if.set_a        = '0;
    in_if.set_b        = '0;
    in_if.target_state = '0;
    idle_on            = 1'b1;
    hold_req           = 1'b0;
    states_cfg         = STATES_RESET;
    for (int unsigned i = 0; i < MAX_STATES; i++) rel_rows[i] = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty relation, extremes, every mode, domain corner cases
    dir_tab.push_back(drow(32, mk_item(MODE_IMAGE, '1, '0, 0), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_CLOSURE, '1, '0, 0), 1, '1));
    dir_tab.push_back(drow(32, mk_item(MODE_CLOSURE, '0, '1, 31), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_ADD_CROSS_SET, 32'h1, 32'h2, 0), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_ADD_CROSS_STATE, 32'h2, '0, 2), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_ADD_CROSS_STATE, 32'h8000_0004, '0, 31), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_IMAGE, 32'h1, '0, 0), 0, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_CLOSURE, 32'h1, '0, 0), 0, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_ADD_CROSS_SET, '1, '0, 0), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_ADD_CROSS_SET, 32'h8000_0000, 32'h1, 0), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_CLOSURE, 32'h8000_0000, '0, 0), 0, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_REMOVE, '1, '1, 0), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_IMAGE, '1, '0, 0), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_ADD_CROSS_SET, '1, '1, 0), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_IMAGE, 32'h8000_0000, '0, 0), 1, '1));
    dir_tab.push_back(drow(32, mk_item(MODE_RSVD_LO, '1, '1, 31), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_RSVD_HI, '1, '0, 0), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_CLEAR, '0, '0, 0), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_IMAGE, '1, '0, 0), 1, '0));
    dir_tab.push_back(drow(32, mk_item(MODE_ADD_CROSS_SET, 32'h8000_0001, 32'h8000_0000, 0),
                           1, '0));
    // shrink: bits above the domain are ignored, the target above it is dropped
    dir_tab.push_back(drow(5, mk_item(MODE_ADD_CROSS_SET, 32'hFFFF_FFE1, '1, 0), 1, '0));
    dir_tab.push_back(drow(5, mk_item(MODE_ADD_CROSS_STATE, '1, '0, 5), 1, '0));
    dir_tab.push_back(drow(5, mk_item(MODE_IMAGE, '1, '0, 0), 0, '0));
    // empty domain touches nothing
    dir_tab.push_back(drow(0, mk_item(MODE_ADD_CROSS_SET, '1, '1, 0), 1, '0));
    dir_tab.push_back(drow(0, mk_item(MODE_CLOSURE, '1, '0, 0), 1, '0));
    // grow again: hidden rows and bits come back
    dir_tab.push_back(drow(32, mk_item(MODE_CLOSURE, 32'h1, '0, 0), 0, '0));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].dom != states_cfg) begin
        drain_results();
        write_states(dir_tab[i].dom);
      end
      send_item(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].want);
    end

    // Random phases, one domain setting each
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_states(CNT_W'(phase_dom[p]));
      idle_on = (p != 5);
      for (int unsigned k = 0; k < phase_len[p]; k++) begin
        if (p == 0 && k == 40) hold_req = 1'b1;
        if (p == 0 && k == 100) begin
          // longest closure: a chain through every state
          send_item(mk_item(MODE_CLEAR, '0, '0, 0), 1'b0, '0);
          for (int unsigned s = 0; s < ROW_W - 1; s++)
            send_item(mk_item(MODE_ADD_CROSS_STATE, ROW_W'(1) << s, '0, TARGET_W'(s + 1)),
                      1'b0, '0);
          send_item(mk_item(MODE_CLOSURE, 32'h1, '0, 0), 1'b0, '0);
        end
        if (p == 3 && k == 75) drain_results();
        send_item(rand_item(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_sets.size() == 0) begin
      $display("tb_state_relation_closure_engine_core OK");
    end else begin
      $display("tb_state_relation_closure_engine_core NOT OK");
    end
    $finish;
  end

endmodule
